@@ sv/lzs_pkg.sv @@
// Shared types and constants for the LZ slide decompressor.
package lzs_pkg;

   localparam int HIST_DEPTH = 4096;
   localparam int ADDR_W     = 12;
   localparam int PC_W       = 13;
   localparam int LANES      = 8;
   localparam int LANE_W     = 3;
   localparam int ROW_W      = ADDR_W - LANE_W;
   localparam int ROWS       = HIST_DEPTH / LANES;
   localparam int CNT_W      = 4;
   localparam int REM_W      = 9;

   localparam logic [REM_W-1:0] PAIR_BASE  = 9'd2;
   localparam logic [REM_W-1:0] EXTRA_BASE = 9'd18;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_TRUNC = 2'd1,
      ERR_DIST  = 2'd2
   } err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte0;
      logic [7:0]       out_byte1;
      logic [7:0]       out_byte2;
      logic [7:0]       out_byte3;
      logic [7:0]       out_byte4;
      logic [7:0]       out_byte5;
      logic [7:0]       out_byte6;
      logic [7:0]       out_byte7;
      logic [CNT_W-1:0] byte_count;
      logic             run_end;
      logic             stream_done;
      logic [1:0]       error_code;
   } rsp_type;

   typedef logic [LANES-1:0][7:0] lane_bytes_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] base;
   } hist_rd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] base;
      logic [CNT_W-1:0]  count;
      lane_bytes_type    bytes;
   } hist_wr_type;

endpackage

@@ sv/lzs_history.sv @@
// Byte-interleaved history RAM: eight banks, eight consecutive bytes per read, up to eight per write.
module lzs_history import lzs_pkg::*; (
   input  logic           clock,
   input  hist_rd_type    rd,
   input  hist_wr_type    wr,
   output lane_bytes_type rd_bytes
);

   logic [7:0]                  mem_ff [LANES][ROWS];
   logic [LANES-1:0][7:0]       q_ff;
   logic [LANE_W-1:0]           rd_lo_ff;

   logic [LANES-1:0][LANE_W-1:0] rd_off;
   logic [LANES-1:0][ADDR_W-1:0] rd_addr;
   logic [LANES-1:0][ROW_W-1:0]  rd_row;
   logic [LANES-1:0][LANE_W-1:0] wr_off;
   logic [LANES-1:0][ADDR_W-1:0] wr_addr;
   logic [LANES-1:0][ROW_W-1:0]  wr_row;
   logic [LANES-1:0]             wr_en;
   lane_bytes_type               wr_data;
   logic [LANES-1:0][LANE_W-1:0] q_sel;

   always_comb begin
      for (int b = 0; b < LANES; b++) begin
         rd_off[b]  = LANE_W'(b) - rd.base[LANE_W-1:0];
         rd_addr[b] = rd.base + ADDR_W'(rd_off[b]);
         rd_row[b]  = rd_addr[b][ADDR_W-1:LANE_W];
         wr_off[b]  = LANE_W'(b) - wr.base[LANE_W-1:0];
         wr_addr[b] = wr.base + ADDR_W'(wr_off[b]);
         wr_row[b]  = wr_addr[b][ADDR_W-1:LANE_W];
         wr_en[b]   = wr.en && (CNT_W'(wr_off[b]) < wr.count);
         wr_data[b] = wr.bytes[wr_off[b]];
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < LANES; b++) begin
         if (wr_en[b]) begin
            mem_ff[b][wr_row[b]] <= wr_data[b];
         end
         if (rd.en) begin
            q_ff[b] <= mem_ff[b][rd_row[b]];
         end
      end
      if (rd.en) begin
         rd_lo_ff <= rd.base[LANE_W-1:0];
      end
   end

   // rotate bank order back into offset order
   always_comb begin
      for (int o = 0; o < LANES; o++) begin
         q_sel[o]    = rd_lo_ff + LANE_W'(o);
         rd_bytes[o] = q_ff[q_sel[o]];
      end
   end

endmodule

@@ sv/lzs_lane_align.sv @@
// Maps history read bytes onto output lanes, repeating short-distance patterns.
module lzs_lane_align import lzs_pkg::*; (
   input  lane_bytes_type   src,
   input  logic [PC_W-1:0]  distance,
   input  logic [PC_W-1:0]  produced,
   input  logic [CNT_W-1:0] count,
   output lane_bytes_type   lanes
);

   logic [LANES-1:0][LANE_W-1:0] src_idx;
   logic [LANES-1:0]             in_range;

   function automatic logic [LANE_W-1:0] small_mod(input logic [LANE_W-1:0] k,
                                                   input logic [LANE_W-1:0] d);
      logic [LANE_W-1:0] r;
      r = k;
      for (int i = 0; i < LANES - 1; i++) begin
         if (r >= d) r = r - d;
      end
      return r;
   endfunction

   // bytes sourced before the stream start read as zero
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         src_idx[k]  = (distance < PC_W'(LANES)) ? small_mod(LANE_W'(k), distance[LANE_W-1:0])
                                                 : LANE_W'(k);
         in_range[k] = ({1'b0, distance} <= ({1'b0, produced} + (PC_W+1)'(src_idx[k])));
         lanes[k]    = ((CNT_W'(k) < count) && in_range[k]) ? src[src_idx[k]] : 8'h00;
      end
   end

endmodule

@@ sv/lz_slide_decompressor.sv @@
// Top level: token parser, copy sequencer and output register of the LZ slide decompressor.
//
// Takes one compressed byte per input beat and emits decompressed bytes in beats of up
// to eight. A flag byte or a pair byte that awaits more input is only accepted. A literal
// is accepted, then written and emitted. A back-reference is accepted, then copied in beats
// of up to eight bytes, each a read of the eight-bank history RAM followed by the write of
// the copied bytes and its output beat; the longest copy is 273 bytes. A new byte is
// accepted once the previous one has produced all its beats, while the last beat may still
// wait in the output register. History reads are bounded by the count of bytes produced in
// the current stream, so the RAM needs no clearing pass after reset.
module lz_slide_decompressor import lzs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EMIT = 4'b0010,
      ST_READ = 4'b0100,
      ST_DATA = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      PH_FIRST = 4'b0001,
      PH_TOKEN = 4'b0010,
      PH_PAIR2 = 4'b0100,
      PH_EXTRA = 4'b1000
   } phase_type;

   localparam logic [3:0] FLAG_COUNT = 4'd8;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [7:0]         flag_bits_ff, flag_bits_in;
   logic [3:0]         flags_left_ff, flags_left_in;
   logic [7:0]         pair_high_ff, pair_high_in;
   logic [PC_W-1:0]    dist_ff, dist_in;
   logic [ADDR_W-1:0]  wp_ff, wp_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic               last_ff, last_in;
   err_type            err_ff, err_in;
   logic [7:0]         lit_ff, lit_in;
   logic               lit_valid_ff, lit_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               slot_free;
   logic               emit_fire;
   logic               data_fire;
   logic               go_lit;
   logic               go_copy;
   logic [PC_W-1:0]    pair_dist;
   logic [PC_W-1:0]    copy_dist;
   logic [CNT_W-1:0]   chunk_cnt;
   logic               chunk_last;
   logic [PC_W:0]      pc_sum;
   hist_rd_type        rd_req;
   hist_wr_type        wr_req;
   lane_bytes_type     rd_bytes;
   lane_bytes_type     aligned;
   lane_bytes_type     lit_lanes;
   lane_bytes_type     out_lanes;

   lzs_history u_history (
      .clock    (clock),
      .rd       (rd_req),
      .wr       (wr_req),
      .rd_bytes (rd_bytes)
   );

   lzs_lane_align u_align (
      .src      (rd_bytes),
      .distance (dist_ff),
      .produced (pc_ff),
      .count    (chunk_cnt),
      .lanes    (aligned)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign emit_fire  = (state_ff == ST_EMIT) && slot_free;
   assign data_fire  = (state_ff == ST_DATA) && slot_free;
   assign pair_dist  = PC_W'({pair_high_ff[3:0], req_data.data_byte}) + PC_W'(1);
   assign chunk_last = (rem_ff <= REM_W'(LANES));
   assign chunk_cnt  = chunk_last ? rem_ff[CNT_W-1:0] : CNT_W'(LANES);

   always_comb begin
      lit_lanes    = '0;
      lit_lanes[0] = lit_valid_ff ? lit_ff : 8'h00;
   end

   assign rd_req.en   = (state_ff == ST_READ);
   assign rd_req.base = wp_ff - dist_ff[ADDR_W-1:0];

   assign wr_req.en    = (emit_fire && lit_valid_ff) || data_fire;
   assign wr_req.base  = wp_ff;
   assign wr_req.count = data_fire ? chunk_cnt : CNT_W'(1);
   assign wr_req.bytes = data_fire ? aligned : lit_lanes;

   assign pc_sum    = (PC_W+1)'(pc_ff) + (PC_W+1)'(wr_req.count);
   assign out_lanes = data_fire ? aligned : lit_lanes;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      flag_bits_in  = flag_bits_ff;
      flags_left_in = flags_left_ff;
      pair_high_in  = pair_high_ff;
      dist_in       = dist_ff;
      wp_in         = wp_ff;
      pc_in         = pc_ff;
      rem_in        = rem_ff;
      last_in       = last_ff;
      err_in        = err_ff;
      lit_in        = lit_ff;
      lit_valid_in  = lit_valid_ff;
      rsp_data_in   = rsp_data_ff;
      go_lit        = 1'b0;
      go_copy       = 1'b0;
      copy_dist     = dist_ff;

      if (wr_req.en) begin
         wp_in = wp_ff + ADDR_W'(wr_req.count);
         pc_in = (pc_sum > (PC_W+1)'(HIST_DEPTH)) ? PC_W'(HIST_DEPTH) : pc_sum[PC_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (phase_ff)
                  PH_FIRST: begin
                     go_lit   = 1'b1;
                     phase_in = PH_TOKEN;
                  end
                  PH_TOKEN: begin
                     if (flags_left_ff == 4'd0) begin
                        flag_bits_in  = req_data.data_byte;
                        flags_left_in = FLAG_COUNT;
                     end else begin
                        flag_bits_in  = {flag_bits_ff[6:0], 1'b0};
                        flags_left_in = flags_left_ff - 4'd1;
                        if (flag_bits_ff[7]) begin
                           pair_high_in = req_data.data_byte;
                           phase_in     = PH_PAIR2;
                        end else begin
                           go_lit = 1'b1;
                        end
                     end
                  end
                  PH_PAIR2: begin
                     dist_in   = pair_dist;
                     copy_dist = pair_dist;
                     if (pair_high_ff[7:4] == 4'd0) begin
                        phase_in = PH_EXTRA;
                     end else begin
                        go_copy  = 1'b1;
                        rem_in   = REM_W'(pair_high_ff[7:4]) + PAIR_BASE;
                        phase_in = PH_TOKEN;
                     end
                  end
                  PH_EXTRA: begin
                     go_copy  = 1'b1;
                     rem_in   = REM_W'(req_data.data_byte) + EXTRA_BASE;
                     phase_in = PH_TOKEN;
                  end
                  default: ;
               endcase
               last_in = req_data.last_byte;
               lit_in  = req_data.data_byte;
               if (go_copy) begin
                  state_in = ST_READ;
                  err_in   = (copy_dist > pc_ff) ? ERR_DIST : ERR_NONE;
               end else if (go_lit) begin
                  state_in     = ST_EMIT;
                  lit_valid_in = 1'b1;
                  err_in       = ERR_NONE;
               end else if (req_data.last_byte) begin
                  state_in     = ST_EMIT;
                  lit_valid_in = 1'b0;
                  err_in       = ERR_TRUNC;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (slot_free) begin
               rem_in   = rem_ff - REM_W'(chunk_cnt);
               state_in = chunk_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (emit_fire || data_fire) begin
         rsp_data_in.out_byte0   = out_lanes[0];
         rsp_data_in.out_byte1   = out_lanes[1];
         rsp_data_in.out_byte2   = out_lanes[2];
         rsp_data_in.out_byte3   = out_lanes[3];
         rsp_data_in.out_byte4   = out_lanes[4];
         rsp_data_in.out_byte5   = out_lanes[5];
         rsp_data_in.out_byte6   = out_lanes[6];
         rsp_data_in.out_byte7   = out_lanes[7];
         rsp_data_in.byte_count  = data_fire ? chunk_cnt : CNT_W'(lit_valid_ff);
         rsp_data_in.run_end     = emit_fire || chunk_last;
         rsp_data_in.stream_done = last_ff && (emit_fire || chunk_last);
         rsp_data_in.error_code  = err_ff;
         // end of stream: restart the decoder for the next stream
         if (last_ff && (emit_fire || chunk_last)) begin
            wp_in         = '0;
            pc_in         = '0;
            flag_bits_in  = '0;
            flags_left_in = '0;
            phase_in      = PH_FIRST;
         end
      end

      if (emit_fire || data_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_FIRST;
         flag_bits_ff  <= '0;
         flags_left_ff <= '0;
         wp_ff         <= '0;
         pc_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         wp_ff         <= wp_in;
         pc_ff         <= pc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_high_ff <= pair_high_in;
      dist_ff      <= dist_in;
      rem_ff       <= rem_in;
      last_ff      <= last_in;
      err_ff       <= err_in;
      lit_ff       <= lit_in;
      lit_valid_ff <= lit_valid_in;
      rsp_data_ff  <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_data_after_read: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_DATA) |-> $past(state_ff == ST_READ))
      else $error("history data beat without a preceding read");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_W'(HIST_DEPTH))
      else $error("fill count beyond history depth");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.stream_done) |-> rsp_data_ff.run_end)
      else $error("stream end on a beat that does not end its run");

   a_copy_pending: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_DATA)) |-> (rem_ff != '0))
      else $error("copy sequencer active with nothing left to copy");
`endif

endmodule

@@ tb/lzs_decode_monitor.sv @@
// Decode monitor: predicts LZ slide decompressor output beats and compares them as they arrive.
module lzs_decode_monitor import lzs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      WANT_FIRST,
      WANT_TOKEN,
      WANT_PAIR_LO,
      WANT_EXTRA
   } phase_type;

   logic [7:0]        hist [HIST_DEPTH];
   logic [ADDR_W-1:0] wr_ptr;
   logic [PC_W-1:0]   produced;
   logic [7:0]        flag_bits;
   logic [3:0]        flags_left;
   phase_type         phase;
   logic [7:0]        pair_hi;
   logic [7:0]        pair_lo;
   logic [7:0]        run_bytes [$];
   logic              dist_bad;
   rsp_type           expected_words [$];
   int                fail_total;

   task automatic restart_stream();
      wr_ptr     = '0;
      produced   = '0;
      flag_bits  = '0;
      flags_left = '0;
      phase      = WANT_FIRST;
      pair_hi    = '0;
      pair_lo    = '0;
   endtask

   task automatic store_byte(input logic [7:0] b);
      hist[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
      if (produced < HIST_DEPTH) produced = produced + 1'b1;
      run_bytes.push_back(b);
   endtask

   task automatic copy_back(input logic [PC_W-1:0] back, input int len);
      logic [7:0]        b;
      logic [ADDR_W-1:0] rd_addr;
      for (int k = 0; k < len; k++) begin
         b = 8'h00;
         rd_addr = wr_ptr - back[ADDR_W-1:0];
         if (back <= produced) b = hist[rd_addr];
         else dist_bad = 1'b1;
         store_byte(b);
      end
   endtask

   function automatic logic [PC_W-1:0] pair_distance();
      return {1'b0, pair_hi[3:0], pair_lo} + 1'b1;
   endfunction

   task automatic decode_byte(input req_type beat);
      logic             done;
      logic             flag_ref;
      err_type          err;
      int               nres;
      int               cnt;
      int               pos;
      logic [63:0]      flat;
      rsp_type          w;
      run_bytes.delete();
      dist_bad = 1'b0;
      done = 1'b0;
      case (phase)
         WANT_FIRST: begin
            store_byte(beat.data_byte);
            phase = WANT_TOKEN;
            done = 1'b1;
         end
         WANT_TOKEN: begin
            if (flags_left == 0) begin
               flag_bits  = beat.data_byte;
               flags_left = 4'd8;
            end else begin
               flag_ref   = flag_bits[7];
               flag_bits  = {flag_bits[6:0], 1'b0};
               flags_left = flags_left - 1'b1;
               if (flag_ref) begin
                  pair_hi = beat.data_byte;
                  phase = WANT_PAIR_LO;
               end else begin
                  store_byte(beat.data_byte);
                  done = 1'b1;
               end
            end
         end
         WANT_PAIR_LO: begin
            pair_lo = beat.data_byte;
            if (pair_hi[7:4] == 4'd0) begin
               phase = WANT_EXTRA;
            end else begin
               copy_back(pair_distance(), int'(pair_hi[7:4]) + int'(PAIR_BASE));
               phase = WANT_TOKEN;
               done = 1'b1;
            end
         end
         default: begin
            copy_back(pair_distance(), int'(beat.data_byte) + int'(EXTRA_BASE));
            phase = WANT_TOKEN;
            done = 1'b1;
         end
      endcase

      err = ERR_NONE;
      if (dist_bad) err = ERR_DIST;
      if (beat.last_byte && !done) err = ERR_TRUNC;
      if (run_bytes.size() == 0 && !beat.last_byte) return;

      nres = (run_bytes.size() + LANES - 1) / LANES;
      if (nres == 0) nres = 1;
      pos = 0;
      for (int r = 0; r < nres; r++) begin
         cnt = run_bytes.size() - pos;
         if (cnt > LANES) cnt = LANES;
         flat = '0;
         for (int j = 0; j < cnt; j++) flat[63-8*j -: 8] = run_bytes[pos+j];
         pos += cnt;
         {w.out_byte0, w.out_byte1, w.out_byte2, w.out_byte3,
          w.out_byte4, w.out_byte5, w.out_byte6, w.out_byte7} = flat;
         w.byte_count  = cnt[CNT_W-1:0];
         w.run_end     = (r == nres - 1);
         w.stream_done = beat.last_byte && (r == nres - 1);
         w.error_code  = err;
         expected_words.push_back(w);
      end
      if (beat.last_byte) restart_stream();
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         fail_total++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   task automatic compare_word(input rsp_type got);
      rsp_type     want;
      logic [63:0] want_flat;
      logic [63:0] got_flat;
      if (expected_words.size() == 0) begin
         fail_total++;
         $display("%0t: unexpected beat, expected none, actual 0x%0h", $time, got);
         return;
      end
      want = expected_words.pop_front();
      want_flat = {want.out_byte0, want.out_byte1, want.out_byte2, want.out_byte3,
                   want.out_byte4, want.out_byte5, want.out_byte6, want.out_byte7};
      got_flat  = {got.out_byte0, got.out_byte1, got.out_byte2, got.out_byte3,
                   got.out_byte4, got.out_byte5, got.out_byte6, got.out_byte7};
      for (int j = 0; j < LANES; j++)
         check_field($sformatf("out_byte%0d", j), want_flat[63-8*j -: 8], got_flat[63-8*j -: 8]);
      check_field("byte_count", want.byte_count, got.byte_count);
      check_field("run_end", want.run_end, got.run_end);
      check_field("stream_done", want.stream_done, got.stream_done);
      check_field("error_code", want.error_code, got.error_code);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) hist[i] = 8'h00;
         restart_stream();
         expected_words.delete();
         fail_total = 0;
      end else begin
         if (rsp_valid && rsp_ready) compare_word(rsp_data);
         if (req_valid && req_ready) decode_byte(req_data);
      end
      mismatches  <= fail_total;
      outstanding <= expected_words.size();
   end

endmodule

@@ tb/tb_lz_slide_decompressor.sv @@
// Testbench top: drives compressed streams into the LZ slide decompressor and reports the verdict.
module tb_lz_slide_decompressor import lzs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      mismatches;
   int      outstanding;

   int         items_sent = 0;
   bit         quiet_mode = 1'b0;
   logic [7:0] stream_bytes [$];
   int         stall_left = 0;
   int         free_left  = 0;

   lz_slide_decompressor dut (.*);
   lzs_decode_monitor    decode_mon (.*);

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("tb_lz_slide_decompressor: FAIL");
      $finish;
   end

   always @(posedge clock) begin : rsp_pacing
      int r;
      r = $urandom_range(0, 99);
      if (free_left > 0) begin
         rsp_ready <= 1'b1;
         free_left--;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (r < 70) begin
         rsp_ready <= 1'b1;
      end else if (r < 93) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else if (r < 97) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(10, 40);
      end else begin
         rsp_ready <= 1'b1;
         free_left = $urandom_range(50, 300);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_byte(input logic [7:0] d, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {d, last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_stream();
      foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // well-formed token stream; truncation cuts it right after a byte that completes no token
   task automatic build_stream(input int tokens, input bit long_copies, input bit allow_bad,
                               input bit truncate);
      logic [7:0]  flag;
      logic [3:0]  nib;
      logic [7:0]  extra;
      logic [11:0] dm1;
      int          produced;
      int          len;
      int          distance;
      int          cut_points [$];
      int          cut;
      stream_bytes.delete();
      stream_bytes.push_back(8'($urandom_range(0, 255)));
      produced = 1;
      flag = '0;
      for (int t = 0; t < tokens; t++) begin
         if (t % 8 == 0) begin
            flag = long_copies ? 8'hFF : 8'($urandom_range(0, 255));
            cut_points.push_back(stream_bytes.size());
            stream_bytes.push_back(flag);
         end
         if (!flag[7 - t % 8]) begin
            stream_bytes.push_back(8'($urandom_range(0, 255)));
            produced++;
         end else begin
            extra = '0;
            if (long_copies) begin
               nib = 4'd0;
               extra = ($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom_range(0, 255));
            end else if ($urandom_range(0, 9) < 7) begin
               nib = 4'($urandom_range(1, 15));
            end else begin
               nib = 4'd0;
               extra = 8'($urandom_range(0, 255));
            end
            len = (nib != 0) ? int'(nib) + int'(PAIR_BASE) : int'(extra) + int'(EXTRA_BASE);
            if (allow_bad && produced < HIST_DEPTH && $urandom_range(0, 3) == 0)
               distance = $urandom_range(produced + 1, HIST_DEPTH);
            else if ($urandom_range(0, 1) == 0)
               distance = $urandom_range(1, (produced < 8) ? produced : 8);
            else
               distance = $urandom_range(1, produced);
            dm1 = 12'(distance - 1);
            cut_points.push_back(stream_bytes.size());
            stream_bytes.push_back({nib, dm1[11:8]});
            if (nib == 4'd0) cut_points.push_back(stream_bytes.size());
            stream_bytes.push_back(dm1[7:0]);
            if (nib == 4'd0) stream_bytes.push_back(extra);
            produced += len;
            if (produced > HIST_DEPTH) produced = HIST_DEPTH;
         end
      end
      if (truncate && cut_points.size() > 0) begin
         cut = cut_points[$urandom_range(0, cut_points.size() - 1)];
         while (stream_bytes.size() > cut + 1) void'(stream_bytes.pop_back());
      end
   endtask

   initial begin : stimulus
      int kind;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single literal stream
      stream_bytes = '{8'h00};
      send_stream();
      // two literals, overlapped copy of 3, max-length copy of 273, literal
      stream_bytes = '{8'hFF, 8'h60, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hA5};
      send_stream();
      // distance 4096 before stream start, then length-18 copy
      stream_bytes = '{8'h5A, 8'hC0, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00};
      send_stream();
      // truncations: on a flag byte, on a pair's first byte, awaiting the extra byte
      stream_bytes = '{8'h11, 8'h80};
      send_stream();
      stream_bytes = '{8'h22, 8'h80, 8'h30};
      send_stream();
      stream_bytes = '{8'h33, 8'h80, 8'h00, 8'h00};
      send_stream();
      drain_results();

      while (items_sent < 390) begin
         quiet_mode = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 62) begin
            build_stream($urandom_range(1, 24), 1'b0, $urandom_range(0, 7) == 0, 1'b0);
         end else if (kind < 70) begin
            build_stream($urandom_range(16, 20), 1'b1, 1'b0, 1'b0);
         end else if (kind < 88) begin
            build_stream($urandom_range(1, 16), 1'b0, $urandom_range(0, 3) == 0, 1'b1);
         end else begin
            stream_bytes.delete();
            repeat ($urandom_range(1, 12)) stream_bytes.push_back(8'($urandom_range(0, 255)));
         end
         send_stream();
         if ($urandom_range(0, 4) == 0) drain_results();
      end

      quiet_mode = 1'b0;
      drain_results();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("tb_lz_slide_decompressor: PASS");
      else
         $display("tb_lz_slide_decompressor: FAIL");
      $finish;
   end

endmodule
